// File: rtl/core/lts_pkg.sv
package lts_pkg;

  // Fixed field widths of the request and response transfers
  localparam int ADDR_W   = 16;
  localparam int ACTION_W = 2;
  localparam int CAP_W    = 4;
  localparam int OCC_W    = 4;
  localparam int COUNT_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               evict_valid;
    logic [ADDR_W-1:0]  evicted_address;
    logic [OCC_W-1:0]   occupancy;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] miss_count;
  } rsp_t;

endpackage

// File: rtl/core/lru_tag_store_top.sv
// Fully associative tag store with least-recently-used replacement.
//
// Channels (valid/ready, a transfer completes when both are high):
//   req  : one request per transfer: action (lookup, insert, remove) and address.
//   rsp  : one response per request, in request order: hit, eviction report,
//          occupancy after the request, saturating lookup hit/miss counts.
//   cfg  : capacity register write (4 bits); always ready. Write only while
//          no request is in flight.
// Timing: a request lands in the input register on its transfer; once the
//   response register is free or draining, the tag compare and rank update
//   run over all ENTRIES slots in parallel, commit the new state and load the
//   response register, and rsp_valid rises with that load. Throughput is one
//   request per cycle while rsp is not held, with back-to-back requests seeing
//   the state left by the one before.
// Stall: while rsp is held, the input register keeps its request and req_ready
//   drops once that register is full; nothing is lost or repeated.
// Reset: all entries invalid, occupancy and counters zero, capacity 4,
//   both pipeline registers empty. Tags are not cleared (read only when valid).
module lru_tag_store_top #(
  parameter int ENTRIES   = 8,
  parameter int ADDR_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  lts_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output lts_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lts_pkg::CAP_W-1:0] cfg_data
);

  // Stored tag width: only the low ADDR_BITS (at most 16) of the 16-bit address matter
  localparam int TAG_W  = (ADDR_BITS < lts_pkg::ADDR_W) ? ADDR_BITS : lts_pkg::ADDR_W;
  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  // Common width for comparing occupancy against capacity
  localparam int WIDE_W = (CNT_W > lts_pkg::CAP_W) ? CNT_W : lts_pkg::CAP_W;

  localparam logic [WIDE_W-1:0] ENTRIES_W = WIDE_W'(ENTRIES);

  // Input register
  lts_pkg::req_t item;
  logic          item_valid;

  // Entry state
  logic [TAG_W-1:0]  entry_tag         [ENTRIES];
  logic [TAG_W-1:0]  entry_tag_next    [ENTRIES];
  logic [ENTRIES-1:0] entry_valid, entry_valid_next;
  logic [RANK_W-1:0] recency_rank      [ENTRIES];
  logic [RANK_W-1:0] recency_rank_next [ENTRIES];
  logic [CNT_W-1:0]  entries_held, entries_held_next;
  logic [lts_pkg::COUNT_W-1:0] hits_seen, hits_seen_next;
  logic [lts_pkg::COUNT_W-1:0] misses_seen, misses_seen_next;
  logic [lts_pkg::CAP_W-1:0]   capacity;

  lts_pkg::rsp_t rsp_next;
  logic          advance;

  // Lookup side
  logic [TAG_W-1:0]   tag;
  logic [ENTRIES-1:0] match, victim, free_vec, free_oh;
  logic               hit_any, evict;
  logic [RANK_W-1:0]  hit_rank, last_rank;
  logic [TAG_W-1:0]   victim_tag;
  logic [WIDE_W-1:0]  cap_eff, held_w;

  // Input register moves on when the response register is free or draining
  assign advance   = item_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !item_valid || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    tag       = item.address[TAG_W-1:0];
    last_rank = RANK_W'(entries_held - CNT_W'(1));

    // Parallel compare over all slots
    hit_rank   = '0;
    victim_tag = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = entry_valid[i] && (entry_tag[i] == tag);
      victim[i] = entry_valid[i] && (recency_rank[i] == last_rank);
      hit_rank   = hit_rank | (match[i] ? recency_rank[i] : '0);
      victim_tag = victim_tag | (victim[i] ? entry_tag[i] : '0);
    end
    hit_any = |match;

    // Capacity clamped to 1..ENTRIES
    held_w  = WIDE_W'(entries_held);
    cap_eff = WIDE_W'(capacity);
    if (capacity == '0) begin
      cap_eff = WIDE_W'(1);
    end
    if (cap_eff > ENTRIES_W) begin
      cap_eff = ENTRIES_W;
    end

    evict = (item.action == lts_pkg::ACT_INSERT) && !hit_any &&
            (held_w >= cap_eff) && (entries_held != '0);

    // Lowest-index free slot, counting the slot the victim leaves
    free_vec = ~entry_valid | (evict ? victim : '0);
    free_oh  = free_vec & (~free_vec + ENTRIES'(1));

    entry_tag_next    = entry_tag;
    entry_valid_next  = entry_valid;
    recency_rank_next = recency_rank;
    entries_held_next = entries_held;
    hits_seen_next    = hits_seen;
    misses_seen_next  = misses_seen;

    unique case (item.action) inside
      lts_pkg::ACT_LOOKUP, lts_pkg::ACT_INSERT: begin
        if (hit_any) begin
          // Promote to most recent; younger entries age by one
          for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
              recency_rank_next[i] = '0;
            end else if (entry_valid[i] && (recency_rank[i] < hit_rank)) begin
              recency_rank_next[i] = recency_rank[i] + RANK_W'(1);
            end
          end
          if (item.action == lts_pkg::ACT_LOOKUP && hits_seen != '1) begin
            hits_seen_next = hits_seen + lts_pkg::COUNT_W'(1);
          end
        end else if (item.action == lts_pkg::ACT_LOOKUP) begin
          if (misses_seen != '1) begin
            misses_seen_next = misses_seen + lts_pkg::COUNT_W'(1);
          end
        end else if (|free_oh) begin
          // Insert of an absent tag: drop victim, fill free slot, age the rest
          for (int i = 0; i < ENTRIES; i++) begin
            if (evict && victim[i]) begin
              entry_valid_next[i]  = 1'b0;
              recency_rank_next[i] = '0;
            end
            if (free_oh[i]) begin
              entry_tag_next[i]    = tag;
              entry_valid_next[i]  = 1'b1;
              recency_rank_next[i] = '0;
            end else if (entry_valid[i] && !(evict && victim[i])) begin
              recency_rank_next[i] = recency_rank[i] + RANK_W'(1);
            end
          end
          entries_held_next = evict ? entries_held : entries_held + CNT_W'(1);
        end
      end
      lts_pkg::ACT_REMOVE: begin
        if (hit_any) begin
          // Close the gap left in the rank order
          for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
              entry_valid_next[i]  = 1'b0;
              recency_rank_next[i] = '0;
            end else if (entry_valid[i] && (recency_rank[i] > hit_rank)) begin
              recency_rank_next[i] = recency_rank[i] - RANK_W'(1);
            end
          end
          entries_held_next = entries_held - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    rsp_next.hit             = hit_any;
    rsp_next.evict_valid     = evict;
    rsp_next.evicted_address = evict ? lts_pkg::ADDR_W'(victim_tag) : '0;
    rsp_next.occupancy       = lts_pkg::OCC_W'(entries_held_next);
    rsp_next.hit_count       = hits_seen_next;
    rsp_next.miss_count      = misses_seen_next;
  end

  // Control and entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      rsp_valid    <= 1'b0;
      entry_valid  <= '0;
      entries_held <= '0;
      hits_seen    <= '0;
      misses_seen  <= '0;
      capacity     <= lts_pkg::CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (req_ready) begin
        item_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid    <= 1'b1;
        entry_valid  <= entry_valid_next;
        entries_held <= entries_held_next;
        hits_seen    <= hits_seen_next;
        misses_seen  <= misses_seen_next;
        recency_rank <= recency_rank_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid) begin
        capacity <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      item <= req;
    end
    if (advance) begin
      rsp       <= rsp_next;
      entry_tag <= entry_tag_next;
    end
  end

endmodule
